/* hdl/rvu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvu_pkg: shared definitions for the Romanian Vigenere UTF-8 stream block
// Constants, register indexes, result item types and the alphabet tables.
// ----------------------------------------------------------------------------
package rvu_pkg;

    localparam int MAX_KEY_LETTERS  = 36;
    localparam int MIN_KEY_LETTERS  = 7;
    localparam int ALPHA_SIZE       = 31;
    localparam int LETTER_W         = 5;
    localparam int KEY_PART_W       = 60;
    localparam int LETTERS_PER_PART = KEY_PART_W / LETTER_W;
    localparam int POS_W            = 6;
    localparam int CFG_IDX_W        = 3;

    localparam logic [7:0] SPACE_BYTE = 8'h20;
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_VAL  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_VAL  = 8'hE0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_PART_LOW  = 3'd0,
        CFG_KEY_PART_MID  = 3'd1,
        CFG_KEY_PART_HIGH = 3'd2,
        CFG_KEY_LENGTH    = 3'd3,
        CFG_MODE          = 3'd4
    } cfg_reg_e;

    typedef struct packed {
        logic [MAX_KEY_LETTERS-1:0][LETTER_W-1:0] key;
        logic [POS_W-1:0]                         key_length;
        logic                                     mode;
    } cfg_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       char_error;
        logic       run_last;
        logic       message_done;
    } item_t;

    typedef struct packed {
        logic [1:0] cnt;
        item_t      item0;
        item_t      item1;
    } result_set_t;

    typedef struct packed {
        logic                valid;
        logic [LETTER_W-1:0] idx;
    } lookup_t;

    // UTF-8 code of each alphabet letter, two-byte letters as hi:lo.
    function automatic logic [15:0] letter_code(input logic [LETTER_W-1:0] idx);
        logic [15:0] code;
        case (idx)
            5'd0:  code = 16'h0041;
            5'd1:  code = 16'hC482;
            5'd2:  code = 16'hC382;
            5'd3:  code = 16'h0042;
            5'd4:  code = 16'h0043;
            5'd5:  code = 16'h0044;
            5'd6:  code = 16'h0045;
            5'd7:  code = 16'h0046;
            5'd8:  code = 16'h0047;
            5'd9:  code = 16'h0048;
            5'd10: code = 16'h0049;
            5'd11: code = 16'hC38E;
            5'd12: code = 16'h004A;
            5'd13: code = 16'h004B;
            5'd14: code = 16'h004C;
            5'd15: code = 16'h004D;
            5'd16: code = 16'h004E;
            5'd17: code = 16'h004F;
            5'd18: code = 16'h0050;
            5'd19: code = 16'h0051;
            5'd20: code = 16'h0052;
            5'd21: code = 16'h0053;
            5'd22: code = 16'hC898;
            5'd23: code = 16'h0054;
            5'd24: code = 16'hC89A;
            5'd25: code = 16'h0055;
            5'd26: code = 16'h0056;
            5'd27: code = 16'h0057;
            5'd28: code = 16'h0058;
            5'd29: code = 16'h0059;
            5'd30: code = 16'h005A;
            default: code = 16'h0000;
        endcase
        return code;
    endfunction

    // Folds lower case and the cedilla forms onto the upper-case letters,
    // then finds the letter by comparing against every table entry.
    function automatic lookup_t letter_index(input logic [15:0] code_in);
        logic [15:0] code;
        lookup_t     res;
        code = code_in;
        res  = '0;
        if (code >= 16'h0061 && code <= 16'h007A) begin
            code = code - 16'h0020;
        end
        case (code)
            16'hC483: code = 16'hC482;
            16'hC3A2: code = 16'hC382;
            16'hC3AE: code = 16'hC38E;
            16'hC899: code = 16'hC898;
            16'hC59F: code = 16'hC898;
            16'hC89B: code = 16'hC89A;
            16'hC5A3: code = 16'hC89A;
            default:  code = code;
        endcase
        for (int k = 0; k < ALPHA_SIZE; k++) begin
            if (letter_code(LETTER_W'(k)) == code) begin
                res.valid = 1'b1;
                res.idx   = LETTER_W'(k);
            end
        end
        return res;
    endfunction

endpackage

/* hdl/rvu_ifs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvu_ifs: channel interfaces
// Input byte channel, result item channel and configuration write channel.
// ----------------------------------------------------------------------------
interface rvu_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       message_end;

    modport source (output valid, output in_byte, output message_end, input ready);
    modport sink   (input valid, input in_byte, input message_end, output ready);
endinterface

interface rvu_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       char_error;
    logic       run_last;
    logic       message_done;

    modport source (output valid, output out_byte, output char_error,
                    output run_last, output message_done, input ready);
    modport sink   (input valid, input out_byte, input char_error,
                    input run_last, input message_done, output ready);
endinterface

interface rvu_cfg_if;
    import rvu_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [KEY_PART_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/romanian_vigenere_utf8_stream.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// romanian_vigenere_utf8_stream: Vigenere cipher over Romanian UTF-8 text
// Takes one message byte per request and returns the enciphered or
// deciphered letter as UTF-8 bytes, or an error item per bad character.
// ----------------------------------------------------------------------------
// An input byte is taken into an input register and decoded from there; its
// results move into a two-slot result register once that register is free,
// and from there the first result is offered. The result port drains one
// byte per cycle while the receiver is ready, so a byte that completes a
// two-byte letter (A-breve, A-circumflex, I-circumflex, S-comma, T-comma)
// holds back the next input byte longer than one that yields one byte or
// none; the result register port sets that pace.
// Configuration is written through its own channel, which is always ready,
// and must only be written while the block is idle. There is no clearing
// pass after reset.
module romanian_vigenere_utf8_stream (
    input logic          clk,
    input logic          rst_n,
    rvu_byte_if.sink     src,
    rvu_result_if.source dst,
    rvu_cfg_if.sink      cfg
);
    import rvu_pkg::*;

    cfg_t        cfg_q;
    logic        res_free;
    logic        res_load;
    result_set_t res_set;

    rvu_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_out (cfg_q)
    );

    rvu_cipher u_cipher (
        .clk      (clk),
        .rst_n    (rst_n),
        .src      (src),
        .cfg_in   (cfg_q),
        .res_free (res_free),
        .res_load (res_load),
        .res_set  (res_set)
    );

    rvu_out_buf u_out (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (res_load),
        .set_in (res_set),
        .free   (res_free),
        .dst    (dst)
    );

endmodule

/* hdl/rvu_cfg_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvu_cfg_regs: configuration register file
// Holds the key letters, the key length and the cipher direction.
// ----------------------------------------------------------------------------
module rvu_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    rvu_cfg_if.sink       cfg,
    output rvu_pkg::cfg_t cfg_out
);
    import rvu_pkg::*;

    logic [KEY_PART_W-1:0] key_low_reg, key_mid_reg, key_high_reg;
    logic [POS_W-1:0]      key_length_reg;
    logic                  mode_reg;
    logic                  wr_en;

    assign cfg.ready = 1'b1;
    assign wr_en     = cfg.valid & cfg.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg    <= '0;
            key_mid_reg    <= '0;
            key_high_reg   <= '0;
            key_length_reg <= POS_W'(MIN_KEY_LETTERS);
            mode_reg       <= 1'b0;
        end
        else if (wr_en)
        begin
            case (cfg_reg_e'(cfg.index))
                CFG_KEY_PART_LOW:  key_low_reg    <= cfg.data;
                CFG_KEY_PART_MID:  key_mid_reg    <= cfg.data;
                CFG_KEY_PART_HIGH: key_high_reg   <= cfg.data;
                CFG_KEY_LENGTH:    key_length_reg <= cfg.data[POS_W-1:0];
                CFG_MODE:          mode_reg       <= cfg.data[0];
                default:           ;
            endcase
        end
    end

    assign cfg_out.key        = {key_high_reg, key_mid_reg, key_low_reg};
    assign cfg_out.key_length = key_length_reg;
    assign cfg_out.mode       = mode_reg;

endmodule

/* hdl/rvu_cipher.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvu_cipher: input register, UTF-8 gathering and letter shift
// Registers one input byte, decodes it against the gathering state and
// hands the resulting bytes to the result buffer in a single pass.
// ----------------------------------------------------------------------------
module rvu_cipher (
    input  logic                 clk,
    input  logic                 rst_n,
    rvu_byte_if.sink             src,
    input  rvu_pkg::cfg_t        cfg_in,
    input  logic                 res_free,
    output logic                 res_load,
    output rvu_pkg::result_set_t res_set
);
    import rvu_pkg::*;

    logic             in_valid_reg, in_valid_next;
    logic [7:0]       in_byte_reg;
    logic             in_end_reg;
    logic [15:0]      held_reg, held_next;
    logic [1:0]       pend_reg, pend_next;
    logic [POS_W-1:0] pos_reg, pos_next;

    logic                advance;
    logic                accept;
    logic                do_char;
    logic                err3;
    logic                trunc;
    logic [15:0]         code;
    lookup_t             lookup;
    logic [POS_W-1:0]    len;
    logic [POS_W-1:0]    pos;
    logic [POS_W-1:0]    pos_inc;
    logic [LETTER_W-1:0] key_letter;
    logic [5:0]          addend;
    logic [5:0]          sum;
    logic [LETTER_W-1:0] shifted;
    logic [15:0]         enc;
    result_set_t         set_c;

    // Key length is clamped to the supported range before use.
    always_comb
    begin
        if (cfg_in.key_length < POS_W'(MIN_KEY_LETTERS))
            len = POS_W'(MIN_KEY_LETTERS);
        else if (cfg_in.key_length > POS_W'(MAX_KEY_LETTERS))
            len = POS_W'(MAX_KEY_LETTERS);
        else
            len = cfg_in.key_length;
    end

    assign pos        = (pos_reg < len) ? pos_reg : '0;
    assign pos_inc    = (pos + 1'b1 >= len) ? '0 : pos + 1'b1;
    assign key_letter = cfg_in.key[pos];

    // Decode the byte against the gathering state.
    always_comb
    begin
        held_next = held_reg;
        pend_next = pend_reg;
        do_char   = 1'b0;
        err3      = 1'b0;
        code      = '0;
        if (in_byte_reg != SPACE_BYTE)
        begin
            case (pend_reg)
                2'd0:
                begin
                    if ((in_byte_reg & LEAD2_MASK) == LEAD2_VAL)
                    begin
                        held_next = {8'h00, in_byte_reg};
                        pend_next = 2'd1;
                    end
                    else if ((in_byte_reg & LEAD3_MASK) == LEAD3_VAL)
                    begin
                        held_next = {8'h00, in_byte_reg};
                        pend_next = 2'd2;
                    end
                    else
                    begin
                        do_char = 1'b1;
                        code    = {8'h00, in_byte_reg};
                    end
                end
                2'd2:
                begin
                    held_next = {held_reg[7:0], in_byte_reg};
                    pend_next = 2'd1;
                end
                default:
                begin
                    // A third byte closes a three-byte sequence, never a letter.
                    if (held_reg[15:8] != 8'h00)
                        err3 = 1'b1;
                    else
                    begin
                        do_char = 1'b1;
                        code    = {held_reg[7:0], in_byte_reg};
                    end
                    held_next = '0;
                    pend_next = 2'd0;
                end
            endcase
        end
        trunc = in_end_reg && (pend_next != 2'd0);
        if (in_end_reg)
        begin
            held_next = '0;
            pend_next = 2'd0;
        end
    end

    assign lookup  = letter_index(code);
    assign addend  = cfg_in.mode ? (6'(ALPHA_SIZE) - {1'b0, key_letter}) : {1'b0, key_letter};
    assign sum     = {1'b0, lookup.idx} + addend;
    assign shifted = (sum >= 6'(ALPHA_SIZE)) ? LETTER_W'(sum - 6'(ALPHA_SIZE))
                                             : sum[LETTER_W-1:0];
    assign enc     = letter_code(shifted);

    always_comb
    begin
        pos_next = pos_reg;
        if (do_char && lookup.valid)
            pos_next = pos_inc;
        if (in_end_reg)
            pos_next = '0;
    end

    // Assemble up to two result items and mark the last one.
    always_comb
    begin
        set_c = '0;
        if (do_char)
        begin
            if (!lookup.valid)
            begin
                set_c.item0.char_error = 1'b1;
                set_c.cnt              = 2'd1;
            end
            else if (enc[15:8] != 8'h00)
            begin
                set_c.item0.out_byte = enc[15:8];
                set_c.item1.out_byte = enc[7:0];
                set_c.cnt            = 2'd2;
            end
            else
            begin
                set_c.item0.out_byte = enc[7:0];
                set_c.cnt            = 2'd1;
            end
        end
        if (err3 || trunc)
        begin
            set_c.item0.char_error = 1'b1;
            set_c.cnt              = 2'd1;
        end
        if (set_c.cnt == 2'd2)
        begin
            set_c.item1.run_last     = 1'b1;
            set_c.item1.message_done = in_end_reg;
        end
        else if (set_c.cnt == 2'd1)
        begin
            set_c.item0.run_last     = 1'b1;
            set_c.item0.message_done = in_end_reg;
        end
    end

    // An item that yields nothing never waits for the result buffer.
    assign advance   = in_valid_reg && ((set_c.cnt == 2'd0) || res_free);
    assign res_load  = advance && (set_c.cnt != 2'd0);
    assign res_set   = set_c;
    assign src.ready = !in_valid_reg || advance;
    assign accept    = src.valid && src.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            held_reg     <= '0;
            pend_reg     <= '0;
            pos_reg      <= '0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (advance)
            begin
                held_reg <= held_next;
                pend_reg <= pend_next;
                pos_reg  <= pos_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg <= src.in_byte;
            in_end_reg  <= src.message_end;
        end
    end

endmodule

/* hdl/rvu_out_buf.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvu_out_buf: two-slot result register
// Holds one input byte's result items; presents one per cycle while dst.ready.
// ----------------------------------------------------------------------------
module rvu_out_buf (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  rvu_pkg::result_set_t set_in,
    output logic                 free,
    rvu_result_if.source         dst
);
    import rvu_pkg::*;

    logic [1:0] cnt_reg, cnt_next;
    item_t      slot0_reg, slot0_next;
    item_t      slot1_reg, slot1_next;
    logic       take;

    assign dst.valid        = (cnt_reg != 2'd0);
    assign dst.out_byte     = slot0_reg.out_byte;
    assign dst.char_error   = slot0_reg.char_error;
    assign dst.run_last     = slot0_reg.run_last;
    assign dst.message_done = slot0_reg.message_done;

    assign take = dst.valid && dst.ready;
    // Free when empty or when the last held item leaves in this cycle.
    assign free = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && dst.ready);

    always_comb
    begin
        cnt_next   = cnt_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (take)
        begin
            if (cnt_reg == 2'd2)
            begin
                slot0_next = slot1_reg;
                cnt_next   = 2'd1;
            end
            else
                cnt_next = 2'd0;
        end
        if (load)
        begin
            slot0_next = set_in.item0;
            slot1_next = set_in.item1;
            cnt_next   = set_in.cnt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

/* hdl/rvu_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvu_checker: port-level checks on the result channel
// Watches the result items the block presents and the order they come in.
// ----------------------------------------------------------------------------
module rvu_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       char_error,
    input logic       run_last,
    input logic       message_done
);

    // A stalled result request keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte)
            && $stable(char_error) && $stable(run_last) && $stable(message_done))
        else $error("stalled result request changed");

    // Error items carry a zero byte and always stand alone.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && char_error |-> (out_byte == 8'h00) && run_last)
        else $error("error item malformed");

    // A lead byte is followed by its continuation; any other byte ends the run.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !char_error |-> run_last == (out_byte[7:6] != 2'b11))
        else $error("run_last does not match the letter encoding");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && message_done |-> run_last)
        else $error("message end marked on an inner item");

endmodule

bind romanian_vigenere_utf8_stream rvu_checker u_rvu_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (dst.valid),
    .out_ready    (dst.ready),
    .out_byte     (dst.out_byte),
    .char_error   (dst.char_error),
    .run_last     (dst.run_last),
    .message_done (dst.message_done)
);

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for romanian_vigenere_utf8_stream
// Drives UTF-8 message bytes and key settings through the three channels.
// The expected cipher bytes, error items and end markers are computed in
// the bench and compared field by field with every accepted result.
// ----------------------------------------------------------------------------
module tb;
    import rvu_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_ITEMS = 850;
    localparam int IDLE_PCT     = 21;

    localparam logic [15:0] ALPHA_UTF8 [ALPHA_SIZE] = '{
        16'h0041, 16'hC482, 16'hC382, 16'h0042, 16'h0043, 16'h0044, 16'h0045,
        16'h0046, 16'h0047, 16'h0048, 16'h0049, 16'hC38E, 16'h004A, 16'h004B,
        16'h004C, 16'h004D, 16'h004E, 16'h004F, 16'h0050, 16'h0051, 16'h0052,
        16'h0053, 16'hC898, 16'h0054, 16'hC89A, 16'h0055, 16'h0056, 16'h0057,
        16'h0058, 16'h0059, 16'h005A
    };

    logic clk;
    logic rst_n;

    rvu_byte_if   byte_ch ();
    rvu_result_if res_ch ();
    rvu_cfg_if    cfg_ch ();

    romanian_vigenere_utf8_stream u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .src   (byte_ch),
        .dst   (res_ch),
        .cfg   (cfg_ch)
    );

    // Shadow copy of the key settings and the decoder state.
    logic [LETTER_W-1:0] key_ltr [MAX_KEY_LETTERS];
    logic [POS_W-1:0]    key_len;
    logic                decrypt;
    logic [15:0]         held;
    int                  held_cnt;
    int                  key_pos;

    item_t out_due [$];
    item_t step_buf [2];
    int    step_cnt;

    int    bad_results;
    int    cycles;
    int    sent_count;
    bit    stall_free;

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("romanian_vigenere_utf8_stream verification failed");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        res_ch.ready <= stall_free || ($urandom_range(99) >= IDLE_PCT);
    end

    // ------------------------------------------------------------------------
    // Cipher prediction
    // ------------------------------------------------------------------------
    function automatic int alpha_of(input logic [15:0] code);
        logic [15:0] c;
        int          found;
        c     = code;
        found = -1;
        if (c >= 16'h0061 && c <= 16'h007A)
        begin
            c = c - 16'h0020;
        end
        case (c)
            16'hC483:           c = 16'hC482;
            16'hC3A2:           c = 16'hC382;
            16'hC3AE:           c = 16'hC38E;
            16'hC899, 16'hC59F: c = 16'hC898;
            16'hC89B, 16'hC5A3: c = 16'hC89A;
            default:            c = c;
        endcase
        for (int k = 0; k < ALPHA_SIZE; k++)
        begin
            if (ALPHA_UTF8[k] == c)
            begin
                found = k;
            end
        end
        return found;
    endfunction

    task automatic emit(input logic [7:0] b, input logic err);
        if (step_cnt < 2)
        begin
            step_buf[step_cnt].out_byte     = b;
            step_buf[step_cnt].char_error   = err;
            step_buf[step_cnt].run_last     = 1'b0;
            step_buf[step_cnt].message_done = 1'b0;
            step_cnt++;
        end
    endtask

    task automatic cipher_letter(input logic [15:0] code);
        int          idx;
        int          len;
        int          pos;
        int          c;
        logic [15:0] enc;
        idx = alpha_of(code);
        if (idx < 0)
        begin
            emit(8'h00, 1'b1);
        end
        else
        begin
            len = int'(key_len);
            if (len < MIN_KEY_LETTERS)
            begin
                len = MIN_KEY_LETTERS;
            end
            if (len > MAX_KEY_LETTERS)
            begin
                len = MAX_KEY_LETTERS;
            end
            pos = (key_pos < len) ? key_pos : 0;
            // A key letter of 31 wraps to a shift of zero in both directions.
            if (decrypt)
            begin
                c = idx + ALPHA_SIZE - int'(key_ltr[pos]);
            end
            else
            begin
                c = idx + int'(key_ltr[pos]);
            end
            if (c >= ALPHA_SIZE)
            begin
                c -= ALPHA_SIZE;
            end
            enc = ALPHA_UTF8[c];
            if (enc > 16'h00FF)
            begin
                emit(enc[15:8], 1'b0);
            end
            emit(enc[7:0], 1'b0);
            pos++;
            key_pos = (pos >= len) ? 0 : pos;
        end
    endtask

    task automatic cipher_byte(input logic [7:0] b, input logic last);
        step_cnt = 0;
        if (b != SPACE_BYTE)
        begin
            if (held_cnt == 0)
            begin
                if ((b & LEAD2_MASK) == LEAD2_VAL)
                begin
                    held     = {8'h00, b};
                    held_cnt = 1;
                end
                else if ((b & LEAD3_MASK) == LEAD3_VAL)
                begin
                    held     = {8'h00, b};
                    held_cnt = 2;
                end
                else
                begin
                    cipher_letter({8'h00, b});
                end
            end
            else if (held_cnt == 2)
            begin
                held     = {held[7:0], b};
                held_cnt = 1;
            end
            else
            begin
                // Held bytes above one byte mean this closes a 3-byte sequence.
                if (held > 16'h00FF)
                begin
                    emit(8'h00, 1'b1);
                end
                else
                begin
                    cipher_letter({held[7:0], b});
                end
                held     = '0;
                held_cnt = 0;
            end
        end
        if (last)
        begin
            if (held_cnt != 0)
            begin
                emit(8'h00, 1'b1);
            end
            held     = '0;
            held_cnt = 0;
            key_pos  = 0;
        end
        if (step_cnt > 0)
        begin
            step_buf[step_cnt-1].run_last     = 1'b1;
            step_buf[step_cnt-1].message_done = last;
        end
        for (int k = 0; k < step_cnt; k++)
        begin
            out_due = {out_due, step_buf[k]};
        end
    endtask

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        item_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (out_due.size() == 0)
            begin
                if (bad_results < 10)
                begin
                    $display("unexpected result: out_byte=%h char_error=%b run_last=%b done=%b",
                             res_ch.out_byte, res_ch.char_error, res_ch.run_last,
                             res_ch.message_done);
                end
                bad_results++;
            end
            else
            begin
                want = out_due.pop_front();
                if (res_ch.out_byte !== want.out_byte ||
                    res_ch.char_error !== want.char_error ||
                    res_ch.run_last !== want.run_last ||
                    res_ch.message_done !== want.message_done)
                begin
                    if (bad_results < 10)
                    begin
                        $display("mismatch: expected byte=%h err=%b last=%b done=%b",
                                 want.out_byte, want.char_error, want.run_last,
                                 want.message_done);
                        $display("          actual   byte=%h err=%b last=%b done=%b",
                                 res_ch.out_byte, res_ch.char_error,
                                 res_ch.run_last, res_ch.message_done);
                    end
                    bad_results++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic last);
        @(negedge clk);
        while (!stall_free && $urandom_range(99) < IDLE_PCT)
        begin
            byte_ch.valid = 1'b0;
            @(negedge clk);
        end
        byte_ch.valid       = 1'b1;
        byte_ch.in_byte     = b;
        byte_ch.message_end = last;
        do
        begin
            @(posedge clk);
        end
        while (!byte_ch.ready);
        cipher_byte(b, last);
        sent_count++;
    endtask

    task automatic send_bytes(input logic [7:0] seq [$], input bit close);
        for (int k = 0; k < seq.size(); k++)
        begin
            send_byte(seq[k], close && (k == seq.size() - 1));
        end
    endtask

    // The block may still hold a request that yields nothing, so a few more
    // cycles pass after the last expected result.
    task automatic wait_idle();
        @(negedge clk);
        byte_ch.valid = 1'b0;
        while (out_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_e r, input logic [KEY_PART_W-1:0] d);
        @(negedge clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = r;
        cfg_ch.data  = d;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ch.ready);
        case (r)
            CFG_KEY_PART_LOW:
                for (int i = 0; i < LETTERS_PER_PART; i++)
                    key_ltr[i] = d[LETTER_W*i +: LETTER_W];
            CFG_KEY_PART_MID:
                for (int i = 0; i < LETTERS_PER_PART; i++)
                    key_ltr[LETTERS_PER_PART+i] = d[LETTER_W*i +: LETTER_W];
            CFG_KEY_PART_HIGH:
                for (int i = 0; i < LETTERS_PER_PART; i++)
                    key_ltr[2*LETTERS_PER_PART+i] = d[LETTER_W*i +: LETTER_W];
            CFG_KEY_LENGTH:
                key_len = d[POS_W-1:0];
            CFG_MODE:
                decrypt = d[0];
            default:
                ;
        endcase
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Random message content
    // ------------------------------------------------------------------------
    function automatic logic [KEY_PART_W-1:0] rand_wide();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[KEY_PART_W-1:0];
    endfunction

    task automatic add_random_char(ref logic [7:0] msg [$]);
        int          roll;
        int          idx;
        int          form;
        logic [15:0] code;
        roll = $urandom_range(99);
        if (roll < 52)
        begin
            idx  = $urandom_range(ALPHA_SIZE - 1);
            code = ALPHA_UTF8[idx];
            form = $urandom_range(2);
            if (code <= 16'h00FF)
            begin
                msg = {msg, ((form == 0) ? (code[7:0] | 8'h20) : code[7:0])};
            end
            else
            begin
                if (form == 1)
                begin
                    case (idx)
                        1:       code = 16'hC483;
                        2:       code = 16'hC3A2;
                        11:      code = 16'hC3AE;
                        22:      code = 16'hC899;
                        default: code = 16'hC89B;
                    endcase
                end
                else if (form == 2 && idx == 22)
                begin
                    code = 16'hC59F;
                end
                else if (form == 2 && idx == 24)
                begin
                    code = 16'hC5A3;
                end
                msg = {msg, code[15:8]};
                // A space inside a sequence is dropped without breaking it.
                if ($urandom_range(99) < 5)
                begin
                    msg = {msg, SPACE_BYTE};
                end
                msg = {msg, code[7:0]};
            end
        end
        else if (roll < 62)
        begin
            msg = {msg, SPACE_BYTE};
        end
        else if (roll < 72)
        begin
            msg = {msg, 8'($urandom_range(127))};
        end
        else if (roll < 80)
        begin
            msg = {msg, (LEAD2_VAL | 8'($urandom_range(31)))};
            msg = {msg, 8'($urandom_range(255))};
        end
        else if (roll < 87)
        begin
            msg = {msg, (LEAD3_VAL | 8'($urandom_range(15)))};
            msg = {msg, 8'($urandom_range(255))};
            msg = {msg, 8'($urandom_range(255))};
        end
        else if (roll < 93)
        begin
            msg = {msg, (8'h80 | 8'($urandom_range(63)))};
        end
        else
        begin
            msg = {msg, 8'($urandom_range(255))};
        end
    endtask

    task automatic send_random_message(input bit close);
        logic [7:0] msg [$];
        int         nchars;
        int         roll;
        nchars = $urandom_range(1, 12);
        for (int k = 0; k < nchars; k++)
        begin
            add_random_char(msg);
        end
        // Sometimes the message stops in the middle of a character.
        roll = $urandom_range(99);
        if (close && roll < 6)
        begin
            msg = {msg, (LEAD2_VAL | 8'($urandom_range(31)))};
        end
        else if (close && roll < 12)
        begin
            msg = {msg, (LEAD3_VAL | 8'($urandom_range(15)))};
            if (roll < 9)
            begin
                msg = {msg, 8'($urandom_range(255))};
            end
        end
        send_bytes(msg, close);
    endtask

    task automatic randomize_config();
        logic [KEY_PART_W-1:0] d;
        int                    roll;
        wait_idle();
        for (int r = 0; r < 3; r++)
        begin
            roll = $urandom_range(99);
            if (roll < 8)
            begin
                d = '1;
            end
            else if (roll < 14)
            begin
                d = '0;
            end
            else
            begin
                d = rand_wide();
            end
            write_reg(cfg_reg_e'(r), d);
        end
        d    = rand_wide();
        roll = $urandom_range(99);
        if (roll < 25)
        begin
            d[POS_W-1:0] = POS_W'($urandom_range(0, MIN_KEY_LETTERS));
        end
        else if (roll < 50)
        begin
            d[POS_W-1:0] = POS_W'($urandom_range(MAX_KEY_LETTERS, 63));
        end
        else
        begin
            d[POS_W-1:0] = POS_W'($urandom_range(MIN_KEY_LETTERS, MAX_KEY_LETTERS));
        end
        write_reg(CFG_KEY_LENGTH, d);
        write_reg(CFG_MODE, rand_wide());
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_reset_key();
        // The key is all zero after reset, so letters pass through unchanged.
        send_bytes('{8'h00, 8'h61, 8'h5A, 8'hFF}, 1'b1);
    endtask

    task automatic test_letter_folds();
        wait_idle();
        write_reg(CFG_KEY_PART_LOW, 60'h0FEDCBA98765432);
        write_reg(CFG_MODE, '0);
        send_bytes('{8'hC4, 8'h83, 8'hC3, 8'hAE, 8'hC5, 8'h9F, 8'hC5, 8'hA3}, 1'b1);
    endtask

    task automatic test_bad_chars();
        send_bytes('{8'h37, 8'h80, 8'hE2, 8'h82, 8'hAC, 8'hC5, 8'h9E}, 1'b1);
    endtask

    task automatic test_truncated();
        send_bytes('{8'hC3}, 1'b1);
        send_bytes('{8'hE2, 8'h82}, 1'b1);
        // A lone space at the end yields nothing at all.
        send_bytes('{SPACE_BYTE}, 1'b1);
    endtask

    task automatic test_key_edges();
        wait_idle();
        write_reg(CFG_KEY_PART_LOW, '1);
        write_reg(CFG_KEY_PART_MID, '0);
        write_reg(CFG_KEY_PART_HIGH, 60'hAAAAAAAAAAAAAAA);
        write_reg(CFG_KEY_LENGTH, {54'h3FFFFFFFFFFFFF, 6'd0});
        write_reg(CFG_MODE, '1);
        send_bytes('{8'h51, 8'hC8, 8'h9A}, 1'b1);
    endtask

    task automatic test_random_traffic();
        int start;
        int nmsg;
        start = sent_count;
        while (sent_count - start < RANDOM_ITEMS)
        begin
            randomize_config();
            stall_free = (sent_count - start >= 350) && (sent_count - start < 500);
            nmsg = $urandom_range(1, 4);
            for (int m = 0; m < nmsg; m++)
            begin
                // An open message carries its key position across the next
                // settings, which may shorten the key below it.
                send_random_message(!(m == nmsg - 1 && $urandom_range(99) < 25));
            end
        end
        stall_free = 1'b0;
    endtask

    initial
    begin
        rst_n               = 1'b0;
        byte_ch.valid       = 1'b0;
        byte_ch.in_byte     = '0;
        byte_ch.message_end = 1'b0;
        res_ch.ready        = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = CFG_KEY_PART_LOW;
        cfg_ch.data         = '0;
        for (int i = 0; i < MAX_KEY_LETTERS; i++)
        begin
            key_ltr[i] = '0;
        end
        key_len     = POS_W'(MIN_KEY_LETTERS);
        decrypt     = 1'b0;
        held        = '0;
        held_cnt    = 0;
        key_pos     = 0;
        bad_results = 0;
        cycles      = 0;
        sent_count  = 0;
        stall_free  = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        test_reset_key();
        test_letter_folds();
        test_bad_chars();
        test_truncated();
        test_key_edges();
        test_random_traffic();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (out_due.size() != 0)
        begin
            $display("%0d results still expected at the end", out_due.size());
        end
        if (bad_results == 0 && out_due.size() == 0)
        begin
            $display("romanian_vigenere_utf8_stream verification clean");
        end
        else
        begin
            $display("romanian_vigenere_utf8_stream verification failed");
        end
        $finish;
    end

endmodule
